### src/lacm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN actuator calibration master package
// Shared codes, register indexes, the job record and the LIN protected ID.
// ----------------------------------------------------------------------------
package lacm_pkg;

	localparam int DATA_BYTES_DEF = 8;
	localparam int JOB_DEPTH      = 2;

	// Input command codes. A tick also means "no pending request".
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_CAL   = 2'd1;
	localparam logic [1:0] CMD_OPEN  = 2'd2;
	localparam logic [1:0] CMD_CLOSE = 2'd3;

	// Operating modes as seen on mode_now.
	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_CAL_CLOSED = 3'd1;
	localparam logic [2:0] MODE_CAL_OPEN   = 3'd2;
	localparam logic [2:0] MODE_READY      = 3'd3;
	localparam logic [2:0] MODE_OPENING    = 3'd4;
	localparam logic [2:0] MODE_CLOSING    = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_BREAK = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_EXCHANGE_TICKS = 2'd0;
	localparam logic [1:0] REG_COMMAND_ID     = 2'd1;
	localparam logic [1:0] REG_STATUS_ID      = 2'd2;

	localparam logic [7:0] EXCHANGE_TICKS_RST = 8'd2;
	localparam logic [5:0] COMMAND_ID_RST     = 6'h32;
	localparam logic [5:0] STATUS_ID_RST      = 6'h33;

	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] SIGNATURE   = 8'h73;
	localparam logic [7:0] FLAG_MASK   = 8'h06;
	localparam logic [7:0] FLAG_CLOSED = 8'h02;
	localparam logic [7:0] CAL_BITS    = 8'h03;
	localparam logic [7:0] OPEN_BITS   = 8'hF0;
	localparam logic [5:0] DIAG_ID_A   = 6'h3C;
	localparam logic [5:0] DIAG_ID_B   = 6'h3D;

	// One classified input, ready for serialization.
	typedef struct packed {
		logic       xchg;
		logic [2:0] mode;
		logic       learned;
		logic [7:0] data0;
		logic [7:0] pid;
		logic [7:0] csum;
		logic [7:0] spid;
	} job_t;

	function automatic logic [7:0] parity_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

endpackage

### src/lin_actuator_calibration_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN actuator calibration master
// Frame sequencer that drives the calibration and movement of a LIN actuator.
// ----------------------------------------------------------------------------
// Input items (cmd and the reply fields) are written like a queue: an item
// transfers at a clock edge with push high and full low. A request command
// is latched and takes effect on the next tick; ticks carry the status reply.
// Results are read like a queue: while empty is low the oldest result is on
// the result ports, and it transfers at an edge with pop high.
// Each request or quiet tick gives one status-only result. An exchange tick
// gives DATA_BYTES + 7 results (15 by default), one per cycle while pop is
// high. The first result of an item passes through the job queue and the
// output register before it reaches the result ports. The front end
// classifies an item in its accept cycle and queues it (two jobs deep), so
// new items are taken while earlier ones are still being serialized. When
// pop stays low the output holds, the queue fills, and full rises. Reset
// clears the mode, the pending request, the tick counter and both queues,
// and loads the register defaults. The registers are written through
// wr_en, wr_index and wr_data; the user must write them only while the
// block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lin_actuator_calibration_master import lacm_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic       reply_complete,
	input  logic [7:0] reply_signature,
	input  logic [7:0] reply_flags,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] item_kind,
	output logic [7:0] bus_byte,
	output logic       run_last,
	output logic [2:0] mode_now,
	output logic       calibrated
);

	logic accept;
	job_t new_job;
	job_t head_job;
	logic job_avail;
	logic job_deq;

	assign accept = push && !full;

	lacm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.accept          (accept),
		.cmd             (cmd),
		.reply_complete  (reply_complete),
		.reply_signature (reply_signature),
		.reply_flags     (reply_flags),
		.job             (new_job)
	);

	lacm_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (accept),
		.enq_job (new_job),
		.full    (full),
		.deq     (job_deq),
		.avail   (job_avail),
		.head    (head_job)
	);

	lacm_back #(
		.DATA_BYTES (DATA_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (job_avail),
		.job        (head_job),
		.job_deq    (job_deq),
		.empty      (empty),
		.pop        (pop),
		.item_kind  (item_kind),
		.bus_byte   (bus_byte),
		.run_last   (run_last),
		.mode_now   (mode_now),
		.calibrated (calibrated)
	);

	// A frame in progress keeps its job queued, so the next byte follows at once.
	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !run_last) |=> !empty)
		else $error("serializer gap inside a frame");

	// A status-only result always closes its item.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && item_kind == KIND_NONE) |-> run_last)
		else $error("status-only result not marked last");

	// Only frame bytes carry a nonzero byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && item_kind != KIND_FRAME) |-> (bus_byte == 8'h00))
		else $error("nonzero byte on a non-frame result");

endmodule

### src/lacm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN actuator calibration master front end
// Holds the configuration and the control state, consumes requests on ticks
// and turns each accepted input into one job for the serializer.
// ----------------------------------------------------------------------------
module lacm_front import lacm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	input  logic       accept,
	input  logic [1:0] cmd,
	input  logic       reply_complete,
	input  logic [7:0] reply_signature,
	input  logic [7:0] reply_flags,
	output job_t       job
);

	logic [7:0] exchange_ticks_q;
	logic [5:0] command_id_q;
	logic [5:0] status_id_q;
	logic [2:0] mode_q;
	logic       learned_q;
	logic [1:0] pending_q;
	logic [7:0] tick_q;

	logic [2:0] mode_req;
	logic       learned_req;
	logic [2:0] mode_nxt;
	logic       learned_nxt;
	logic [7:0] tick_inc;
	logic       due;
	logic       active;
	logic       reply_ok;
	logic [7:0] prog;
	logic [7:0] data0;
	logic [7:0] pid;
	logic [8:0] sum9;
	logic [7:0] sum8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exchange_ticks_q <= EXCHANGE_TICKS_RST;
			command_id_q     <= COMMAND_ID_RST;
			status_id_q      <= STATUS_ID_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXCHANGE_TICKS: exchange_ticks_q <= wr_data;
				REG_COMMAND_ID:     command_id_q     <= wr_data[5:0];
				REG_STATUS_ID:      status_id_q      <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_req    = mode_q;
		learned_req = learned_q;
		unique case (pending_q)
			CMD_CAL: begin
				mode_req    = MODE_CAL_CLOSED;
				learned_req = 1'b0;
			end
			CMD_OPEN:  if (learned_q) mode_req = MODE_OPENING;
			CMD_CLOSE: if (learned_q) mode_req = MODE_CLOSING;
			default: ;
		endcase

		tick_inc = (tick_q != 8'hFF) ? tick_q + 8'd1 : tick_q;
		due      = (tick_inc >= exchange_ticks_q);

		unique case (mode_req) inside
			MODE_CAL_CLOSED, MODE_CAL_OPEN, MODE_OPENING, MODE_CLOSING: active = 1'b1;
			default: active = 1'b0;
		endcase

		data0 = 8'h00;
		if (mode_req == MODE_CAL_CLOSED || mode_req == MODE_CAL_OPEN)
			data0 = 8'h01 & CAL_BITS;
		if (mode_req == MODE_CAL_OPEN || mode_req == MODE_OPENING)
			data0 = data0 | OPEN_BITS;

		// Diagnostic frames use the classic checksum, which leaves the ID out.
		pid  = parity_id(command_id_q);
		sum9 = {1'b0, data0};
		if (command_id_q != DIAG_ID_A && command_id_q != DIAG_ID_B)
			sum9 = sum9 + {1'b0, pid};
		// Two bytes at most, so one end-around carry is enough.
		sum8 = sum9[7:0] + {7'd0, sum9[8]};

		reply_ok = reply_complete && (reply_signature == SIGNATURE);
		prog     = reply_flags & FLAG_MASK;

		mode_nxt    = mode_req;
		learned_nxt = learned_req;
		if (due && active) begin
			unique case (mode_req)
				MODE_CAL_CLOSED: if (reply_ok && prog == FLAG_CLOSED) mode_nxt = MODE_CAL_OPEN;
				MODE_CAL_OPEN: begin
					if (reply_ok && prog == 8'h00) begin
						mode_nxt    = MODE_READY;
						learned_nxt = 1'b1;
					end
				end
				default: mode_nxt = MODE_READY;
			endcase
		end

		job.data0 = data0;
		job.pid   = pid;
		job.csum  = ~sum8;
		job.spid  = parity_id(status_id_q);
		if (cmd == CMD_TICK) begin
			job.xchg    = due && active;
			job.mode    = mode_nxt;
			job.learned = learned_nxt;
		end else begin
			job.xchg    = 1'b0;
			job.mode    = mode_q;
			job.learned = learned_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			learned_q <= 1'b0;
			pending_q <= CMD_TICK;
			tick_q    <= 8'd0;
		end else if (accept) begin
			if (cmd != CMD_TICK) begin
				pending_q <= cmd;
			end else begin
				pending_q <= CMD_TICK;
				mode_q    <= mode_nxt;
				learned_q <= learned_nxt;
				tick_q    <= due ? 8'd0 : tick_inc;
			end
		end
	end

endmodule

### src/lacm_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN actuator calibration master job queue
// Short queue of classified jobs between the front end and the serializer.
// ----------------------------------------------------------------------------
module lacm_job_fifo import lacm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic enq,
	input  job_t enq_job,
	output logic full,
	input  logic deq,
	output logic avail,
	output job_t head
);

	localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOB_DEPTH + 1);

	job_t             mem_q [JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(JOB_DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq)
			mem_q[wr_ptr_q] <= enq_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (deq)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (enq && !deq)
				count_q <= count_q + 1'b1;
			else if (deq && !enq)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### src/lacm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN actuator calibration master serializer
// Walks each job one result per cycle into the output register, holding while a result waits for pop.
// ----------------------------------------------------------------------------
module lacm_back import lacm_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_avail,
	input  job_t       job,
	output logic       job_deq,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] item_kind,
	output logic [7:0] bus_byte,
	output logic       run_last,
	output logic [2:0] mode_now,
	output logic       calibrated
);

	localparam int IDX_W = $clog2(DATA_BYTES + 7);

	localparam logic [IDX_W-1:0] POS_BREAK1 = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_SYNC1  = IDX_W'(1);
	localparam logic [IDX_W-1:0] POS_PID    = IDX_W'(2);
	localparam logic [IDX_W-1:0] POS_DATA0  = IDX_W'(3);
	localparam logic [IDX_W-1:0] POS_CSUM   = IDX_W'(DATA_BYTES + 3);
	localparam logic [IDX_W-1:0] POS_BREAK2 = IDX_W'(DATA_BYTES + 4);
	localparam logic [IDX_W-1:0] POS_SYNC2  = IDX_W'(DATA_BYTES + 5);
	localparam logic [IDX_W-1:0] POS_SPID   = IDX_W'(DATA_BYTES + 6);

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [2:0]       mode_q;
	logic             cal_q;
	logic [IDX_W-1:0] idx_q;

	logic       advance;
	logic       load;
	logic [1:0] kind_d;
	logic [7:0] byte_d;
	logic       last_d;

	assign advance = !out_valid_q || pop;
	assign load    = advance && job_avail;
	assign job_deq = load && last_d;

	always_comb begin
		kind_d = KIND_FRAME;
		byte_d = 8'h00;
		last_d = 1'b0;
		if (!job.xchg) begin
			kind_d = KIND_NONE;
			last_d = 1'b1;
		end else if (idx_q == POS_BREAK1 || idx_q == POS_BREAK2) begin
			kind_d = KIND_BREAK;
		end else if (idx_q == POS_SYNC1 || idx_q == POS_SYNC2) begin
			byte_d = SYNC_BYTE;
		end else if (idx_q == POS_PID) begin
			byte_d = job.pid;
		end else if (idx_q == POS_DATA0) begin
			byte_d = job.data0;
		end else if (idx_q == POS_CSUM) begin
			byte_d = job.csum;
		end else if (idx_q == POS_SPID) begin
			byte_d = job.spid;
			last_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			out_valid_q <= job_avail;
			if (load)
				idx_q <= last_d ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			last_q <= last_d;
			mode_q <= job.mode;
			cal_q  <= job.learned;
		end
	end

	assign empty      = !out_valid_q;
	assign item_kind  = kind_q;
	assign bus_byte   = byte_q;
	assign run_last   = last_q;
	assign mode_now   = mode_q;
	assign calibrated = cal_q;

endmodule

### verif/lin_actuator_calibration_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN actuator calibration master testbench
// Sends request events and ticks into the block, predicts every bus item and
// status result, and compares each transfer out of the block field by field.
// ----------------------------------------------------------------------------
module lin_actuator_calibration_master_tb;
	import lacm_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 150;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct {
		logic [1:0] cmd;
		logic       complete;
		logic [7:0] sig;
		logic [7:0] flags;
	} lin_event_t;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
		logic [2:0] mode;
		logic       learned;
	} bus_item_t;

	logic       clk;
	logic       arst_n;
	logic       wr_en;
	logic [1:0] wr_index;
	logic [7:0] wr_data;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] cmd = CMD_TICK;
	logic       reply_complete = 1'b0;
	logic [7:0] reply_signature = '0;
	logic [7:0] reply_flags = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [1:0] item_kind;
	logic [7:0] bus_byte;
	logic       run_last;
	logic [2:0] mode_now;
	logic       calibrated;

	// Predicted actuator state and register copies.
	logic [2:0] act_mode = MODE_IDLE;
	logic       act_learned = 1'b0;
	logic [1:0] act_pending = CMD_TICK;
	logic [7:0] act_ticks = '0;
	logic [7:0] cfg_exchange = EXCHANGE_TICKS_RST;
	logic [5:0] cfg_cmd_id = COMMAND_ID_RST;
	logic [5:0] cfg_status_id = STATUS_ID_RST;

	lin_event_t  pending_events[$];
	bus_item_t   expected_bus_items[$];
	lin_event_t  next_event;
	bus_item_t   want;
	logic        next_push;
	bit          took_in = 1'b0;
	bit          sender_rests;
	bit          receiver_rests;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned results_seen = 0;
	int          mismatches = 0;

	lin_actuator_calibration_master dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.reply_complete (reply_complete),
		.reply_signature(reply_signature),
		.reply_flags    (reply_flags),
		.empty          (empty),
		.pop            (pop),
		.item_kind      (item_kind),
		.bus_byte       (bus_byte),
		.run_last       (run_last),
		.mode_now       (mode_now),
		.calibrated     (calibrated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] frame_pid(input logic [5:0] id);
		return {~^(id & 6'b111010), ^(id & 6'b010111), id};
	endfunction

	function automatic bus_item_t bus_word(input logic [1:0] kind, input logic [7:0] data);
		return '{kind: kind, data: data, last: 1'b0, mode: '0, learned: 1'b0};
	endfunction

	// Applies one accepted event to the actuator state and queues the bus items
	// and status results that it causes.
	task automatic predict_bus_items(input lin_event_t ev);
		bus_item_t   frame[$];
		logic [7:0]  data0;
		logic [7:0]  pid;
		logic [7:0]  progress;
		logic        reply_ok;
		int unsigned sum;
		if (ev.cmd != CMD_TICK) begin
			act_pending = ev.cmd;
		end else begin
			case (act_pending)
				CMD_CAL: begin
					act_mode = MODE_CAL_CLOSED;
					act_learned = 1'b0;
				end
				CMD_OPEN: if (act_learned) act_mode = MODE_OPENING;
				CMD_CLOSE: if (act_learned) act_mode = MODE_CLOSING;
				default: ;
			endcase
			act_pending = CMD_TICK;
			if (act_ticks != 8'hFF)
				act_ticks++;
			if (act_ticks >= cfg_exchange) begin
				act_ticks = '0;
				if (act_mode inside {MODE_CAL_CLOSED, MODE_CAL_OPEN, MODE_OPENING,
						MODE_CLOSING}) begin
					data0 = '0;
					if (act_mode inside {MODE_CAL_CLOSED, MODE_CAL_OPEN})
						data0 = 8'h01 & CAL_BITS;
					if (act_mode inside {MODE_CAL_OPEN, MODE_OPENING})
						data0 = data0 | OPEN_BITS;
					pid = frame_pid(cfg_cmd_id);
					// Diagnostic frames use the classic checksum over the data only.
					sum = (cfg_cmd_id == DIAG_ID_A || cfg_cmd_id == DIAG_ID_B) ? 0 : pid;
					sum += data0;
					while (sum > 255)
						sum = (sum & 255) + (sum >> 8);
					frame.push_back(bus_word(KIND_BREAK, 8'h00));
					frame.push_back(bus_word(KIND_FRAME, SYNC_BYTE));
					frame.push_back(bus_word(KIND_FRAME, pid));
					frame.push_back(bus_word(KIND_FRAME, data0));
					for (int i = 1; i < DATA_BYTES_DEF; i++)
						frame.push_back(bus_word(KIND_FRAME, 8'h00));
					frame.push_back(bus_word(KIND_FRAME, ~sum[7:0]));
					frame.push_back(bus_word(KIND_BREAK, 8'h00));
					frame.push_back(bus_word(KIND_FRAME, SYNC_BYTE));
					frame.push_back(bus_word(KIND_FRAME, frame_pid(cfg_status_id)));
					reply_ok = ev.complete && ev.sig == SIGNATURE;
					progress = ev.flags & FLAG_MASK;
					case (act_mode)
						MODE_CAL_CLOSED: if (reply_ok && progress == FLAG_CLOSED)
							act_mode = MODE_CAL_OPEN;
						MODE_CAL_OPEN: if (reply_ok && progress == 8'h00) begin
							act_learned = 1'b1;
							act_mode = MODE_READY;
						end
						default: act_mode = MODE_READY;
					endcase
				end
			end
		end
		if (frame.size() == 0)
			frame.push_back(bus_word(KIND_NONE, 8'h00));
		foreach (frame[i]) begin
			frame[i].mode = act_mode;
			frame[i].learned = act_learned;
		end
		frame[frame.size() - 1].last = 1'b1;
		foreach (frame[i])
			expected_bus_items.push_back(frame[i]);
	endtask

	// Sender: offers the next pending event at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			next_push = push && !took_in;
			sender_rests = $urandom_range(0, 99) < 28 && !(items_taken >= 40 && items_taken < 90);
			if (!next_push && !sender_rests && pending_events.size() != 0) begin
				next_event = pending_events.pop_front();
				cmd <= next_event.cmd;
				reply_complete <= next_event.complete;
				reply_signature <= next_event.sig;
				reply_flags <= next_event.flags;
				next_push = 1'b1;
			end
			push <= next_push;
		end
	end

	// Receiver: pops at random, and once holds off long enough to back up the block.
	always @(negedge clk) begin
		if (arst_n) begin
			receiver_rests = $urandom_range(0, 99) < 28 &&
				!(results_seen >= 600 && results_seen < 900);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else begin
				pop <= !receiver_rests;
			end
		end
	end

	// Monitor: checks result transfers first, then predicts for an input transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bus_items.size() == 0) begin
					if (mismatches < SHOWN_MISMATCHES)
						$display("%0t: bus item %0d arrived with nothing expected", $time,
							results_seen);
					mismatches++;
				end else begin
					want = expected_bus_items.pop_front();
					if (item_kind !== want.kind || bus_byte !== want.data ||
							run_last !== want.last || mode_now !== want.mode ||
							calibrated !== want.learned) begin
						if (mismatches < SHOWN_MISMATCHES)
							$display({"%0t: bus item %0d: expected kind %0d byte %02h last %0b",
								" mode %0d cal %0b, got kind %0d byte %02h last %0b mode %0d cal %0b"},
								$time, results_seen, want.kind, want.data, want.last, want.mode,
								want.learned, item_kind, bus_byte, run_last, mode_now, calibrated);
						mismatches++;
					end
				end
				results_seen++;
			end
			took_in = push && !full;
			if (took_in) begin
				predict_bus_items('{cmd: cmd, complete: reply_complete, sig: reply_signature,
					flags: reply_flags});
				items_taken++;
			end
		end
	end

	task automatic offer_event(input logic [1:0] c, input logic complete,
			input logic [7:0] sig, input logic [7:0] flags);
		pending_events.push_back('{cmd: c, complete: complete, sig: sig, flags: flags});
		items_queued++;
	endtask

	// A tick that mostly carries a valid reply showing the given learning progress.
	task automatic tick_reply(input logic [7:0] progress);
		if ($urandom_range(0, 99) < 85)
			offer_event(CMD_TICK, 1'b1, SIGNATURE, (8'($urandom) & ~FLAG_MASK) | progress);
		else
			offer_event(CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
	endtask

	// Mostly a full calibration followed by moves, sometimes plain noise.
	task automatic add_scenario(input int unsigned pace);
		int unsigned reps;
		if ($urandom_range(0, 99) < 75) begin
			if ($urandom_range(0, 4) == 0)
				offer_event($urandom_range(0, 1) ? CMD_OPEN : CMD_CLOSE, 1'($urandom),
					8'($urandom), 8'($urandom));
			offer_event(CMD_CAL, 1'($urandom), 8'($urandom), 8'($urandom));
			reps = pace * $urandom_range(1, 3);
			repeat (reps) tick_reply(FLAG_CLOSED);
			reps = pace * $urandom_range(1, 3);
			repeat (reps) tick_reply(8'h00);
			repeat ($urandom_range(1, 3)) begin
				offer_event($urandom_range(0, 1) ? CMD_OPEN : CMD_CLOSE, 1'($urandom),
					8'($urandom), 8'($urandom));
				reps = pace * $urandom_range(1, 2);
				repeat (reps) tick_reply(8'($urandom) & FLAG_MASK);
			end
		end else begin
			repeat ($urandom_range(1, 6))
				offer_event(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
					8'($urandom));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		@(posedge clk);
		case (idx)
			REG_EXCHANGE_TICKS: cfg_exchange = value;
			REG_COMMAND_ID: cfg_cmd_id = value[5:0];
			REG_STATUS_ID: cfg_status_id = value[5:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Waits until every event has transferred and every result has come back.
	task automatic wait_for_quiet();
		do
			@(negedge clk);
		while (items_taken != items_queued || expected_bus_items.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int unsigned count, input int unsigned pace);
		int unsigned goal;
		@(posedge clk);
		goal = items_queued + count;
		while (items_queued < goal)
			add_scenario(pace);
		wait_for_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_EXCHANGE_TICKS;
		wr_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed pass at the reset settings: requests before calibration, an
		// overwritten request, rejected replies, then the full calibration and moves.
		@(posedge clk);
		offer_event(CMD_TICK, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_TICK, 1'b1, 8'hFF, 8'hFF);
		offer_event(CMD_OPEN, 1'b1, 8'hFF, 8'hFF);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'h00);
		offer_event(CMD_CLOSE, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'h00);
		offer_event(CMD_CAL, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_OPEN, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_TICK, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_CAL, 1'b1, 8'hFF, 8'hFF);
		offer_event(CMD_TICK, 1'b0, SIGNATURE, FLAG_CLOSED);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, FLAG_CLOSED);
		offer_event(CMD_TICK, 1'b1, 8'h72, FLAG_CLOSED);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'h06);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'h06);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'h00);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'hFB);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'h00);
		offer_event(CMD_TICK, 1'b1, SIGNATURE, 8'hF9);
		offer_event(CMD_OPEN, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_TICK, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_TICK, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_CLOSE, 1'b1, 8'hFF, 8'hFF);
		offer_event(CMD_TICK, 1'b1, 8'hFF, 8'hFF);
		offer_event(CMD_TICK, 1'b1, 8'hFF, 8'hFF);
		offer_event(CMD_CAL, 1'b0, 8'h00, 8'h00);
		offer_event(CMD_TICK, 1'b0, 8'h00, 8'h00);
		wait_for_quiet();

		// Upper ID bits are written set to show that the register drops them.
		write_reg(REG_EXCHANGE_TICKS, 8'd1);
		write_reg(REG_COMMAND_ID, {2'b11, DIAG_ID_A});
		write_reg(REG_STATUS_ID, {2'b10, 6'h00});
		run_random(35, 1);

		// A zero period behaves like one: every tick in an active mode exchanges.
		write_reg(REG_EXCHANGE_TICKS, 8'd0);
		write_reg(REG_COMMAND_ID, {2'b01, DIAG_ID_B});
		write_reg(REG_STATUS_ID, {2'b11, 6'h3F});
		run_random(30, 1);

		write_reg(REG_EXCHANGE_TICKS, 8'd255);
		write_reg(REG_COMMAND_ID, 8'h3F);
		write_reg(REG_STATUS_ID, 8'h15);
		write_reg(REG_UNUSED, 8'($urandom));
		run_random(8, 1);

		// If the tick counter is left above the new period, the next tick is due at once.
		write_reg(REG_EXCHANGE_TICKS, 8'd3);
		write_reg(REG_COMMAND_ID, 8'($urandom));
		write_reg(REG_STATUS_ID, 8'($urandom));
		run_random(28, 3);

		write_reg(REG_EXCHANGE_TICKS, 8'($urandom_range(1, 4)));
		write_reg(REG_COMMAND_ID, 8'h00);
		write_reg(REG_STATUS_ID, 8'($urandom));
		run_random(28, cfg_exchange);

		if (mismatches == 0 && expected_bus_items.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
